// ===== rtl/serial_frame_receiver_crc8_top_defines.svh =====
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CRC8_TOP_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CRC8_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SFR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Constants, status codes and the queue entry shared by the receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Framing constants
  localparam logic [7:0] StartTag  = 8'hFF;
  localparam logic [7:0] CrcPoly   = 8'h8C;
  localparam logic [7:0] HeaderLen = 8'd3;
  localparam logic [7:0] MinFrame  = 8'd8;

  // Frame status codes, reported with the last word of a frame
  localparam logic [1:0] StatusGood   = 2'd0;
  localparam logic [1:0] StatusCrcErr = 2'd1;
  localparam logic [1:0] StatusShort  = 2'd2;

  // One queue entry: either a whole header (three words) or one frame word
  typedef struct packed {
    logic       hdr;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
    logic [1:0] status;
  } sfr_entry_t;

endpackage

// ===== rtl/sfr_if.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver channel interfaces
// Valid/ready channels for received bytes and for deframed frame words.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;
  logic [1:0] frame_status;
  logic       run_last;

  modport source (output valid, output out_byte, output frame_first, output frame_last,
                  output frame_status, output run_last, input ready);
  modport sink   (input valid, input out_byte, input frame_first, input frame_last,
                  input frame_status, input run_last, output ready);
endinterface

// ===== rtl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver front end
// Hunts headers, tracks the frame length, runs the CRC-8 and pushes entries.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_crc8_top_defines.svh"

module sfr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfr_rx_if.sink              rx_i,
  input  logic                q_full_i,
  output logic                push_o,
  output sfr_pkg::sfr_entry_t push_entry_o
);

  // Reflected CRC-8 over one byte, bit by bit
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ sfr_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  logic             in_payload_q, in_payload_d;
  logic [1:0]       header_pos_q, header_pos_d;
  logic [1:0][7:0]  hdr_store_q;
  logic             hdr_wr;
  logic [7:0]       bytes_rem_q, bytes_rem_d;
  logic             crc_pending_q, crc_pending_d;
  logic             short_q, short_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       crc_rx_q, crc_rx_d;
  logic             fire;
  logic [7:0]       crc_step;

  assign rx_i.ready = !q_full_i;
  assign fire       = rx_i.valid && rx_i.ready;
  assign crc_step   = crc8_step(crc_q, rx_i.rx_byte);

  // Classify each accepted word and build the queue entry
  always_comb begin
    in_payload_d  = in_payload_q;
    header_pos_d  = header_pos_q;
    bytes_rem_d   = bytes_rem_q;
    crc_pending_d = crc_pending_q;
    short_d       = short_q;
    crc_d         = crc_q;
    crc_rx_d      = crc_rx_q;
    hdr_wr        = 1'b0;
    push_o        = 1'b0;
    push_entry_o  = '{hdr: 1'b0, b0: rx_i.rx_byte, b1: hdr_store_q[1], b2: rx_i.rx_byte,
                      last: 1'b0, status: sfr_pkg::StatusGood};
    if (fire) begin
      if (!in_payload_q) begin
        if (header_pos_q != 2'd2) begin
          hdr_wr       = 1'b1;
          header_pos_d = header_pos_q + 2'd1;
        end else begin
          header_pos_d = 2'd0;
          if (hdr_store_q[0] == sfr_pkg::StartTag && rx_i.rx_byte > sfr_pkg::HeaderLen) begin
            in_payload_d    = 1'b1;
            bytes_rem_d     = rx_i.rx_byte - sfr_pkg::HeaderLen;
            crc_pending_d   = 1'b1;
            short_d         = rx_i.rx_byte < sfr_pkg::MinFrame;
            crc_d           = '0;
            crc_rx_d        = '0;
            push_o          = 1'b1;
            push_entry_o.hdr = 1'b1;
            push_entry_o.b0 = hdr_store_q[0];
          end
        end
      end else begin
        push_o      = 1'b1;
        bytes_rem_d = bytes_rem_q - 8'd1;
        if (crc_pending_q) begin
          crc_rx_d      = rx_i.rx_byte;
          crc_pending_d = 1'b0;
        end else begin
          crc_d = crc_step;
        end
        if (bytes_rem_q == 8'd1) begin
          in_payload_d      = 1'b0;
          header_pos_d      = 2'd0;
          push_entry_o.last = 1'b1;
          if (short_q) begin
            push_entry_o.status = sfr_pkg::StatusShort;
          end else if (crc_d == crc_rx_d) begin
            push_entry_o.status = sfr_pkg::StatusGood;
          end else begin
            push_entry_o.status = sfr_pkg::StatusCrcErr;
          end
        end
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q  <= 1'b0;
      header_pos_q  <= 2'd0;
      bytes_rem_q   <= '0;
      crc_pending_q <= 1'b0;
      short_q       <= 1'b0;
      crc_q         <= '0;
      crc_rx_q      <= '0;
    end else begin
      in_payload_q  <= in_payload_d;
      header_pos_q  <= header_pos_d;
      bytes_rem_q   <= bytes_rem_d;
      crc_pending_q <= crc_pending_d;
      short_q       <= short_d;
      crc_q         <= crc_d;
      crc_rx_q      <= crc_rx_d;
    end
  end

  // Store the first two header words
  always_ff @(posedge clk_i) begin
    if (hdr_wr) begin
      hdr_store_q[header_pos_q[0]] <= rx_i.rx_byte;
    end
  end

  `SFR_ASSERT(a_payload_has_bytes, in_payload_q |-> (bytes_rem_q != 8'd0), "payload with no bytes left")
  `SFR_ASSERT(a_hunt_pos_range, header_pos_q != 2'd3, "header position out of range")

endmodule

// ===== rtl/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver entry queue
// Short FIFO that decouples the front end from the output sequencer.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_crc8_top_defines.svh"

module sfr_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sfr_pkg::sfr_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output sfr_pkg::sfr_entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sfr_pkg::sfr_entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Write entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `SFR_ASSERT_NEVER(a_push_when_full, push_i && full_o, "push into full queue")
  `SFR_ASSERT_NEVER(a_pop_when_empty, pop_i && !valid_o, "pop from empty queue")

endmodule

// ===== rtl/sfr_back.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver output sequencer
// Pops queue entries and presents them as frame words, one per handshake.
// ----------------------------------------------------------------------------
`include "serial_frame_receiver_crc8_top_defines.svh"

module sfr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  sfr_pkg::sfr_entry_t q_head_i,
  output logic                q_pop_o,
  sfr_tx_if.source            tx_o
);

  // Header word phases
  localparam logic [1:0] PhTag    = 2'd0;
  localparam logic [1:0] PhSecond = 2'd1;
  localparam logic [1:0] PhLength = 2'd2;

  sfr_pkg::sfr_entry_t cur_q;
  logic                cur_valid_q;
  logic [1:0]          phase_q;
  logic                fire;
  logic                finish;

  assign fire    = cur_valid_q && tx_o.ready;
  assign finish  = fire && (!cur_q.hdr || phase_q == PhLength);
  assign q_pop_o = q_valid_i && (!cur_valid_q || finish);

  // Drive the output word from the held entry
  always_comb begin
    tx_o.valid        = cur_valid_q;
    tx_o.frame_first  = cur_q.hdr && phase_q == PhTag;
    tx_o.frame_last   = !cur_q.hdr && cur_q.last;
    tx_o.frame_status = cur_q.hdr ? sfr_pkg::StatusGood : cur_q.status;
    tx_o.run_last     = !cur_q.hdr || phase_q == PhLength;
    tx_o.out_byte     = cur_q.b0;
    if (cur_q.hdr) begin
      unique case (phase_q)
        PhTag:    tx_o.out_byte = cur_q.b0;
        PhSecond: tx_o.out_byte = cur_q.b1;
        PhLength: tx_o.out_byte = cur_q.b2;
        default:  tx_o.out_byte = cur_q.b0;
      endcase
    end
  end

  // Load, advance and drop the current entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= PhTag;
    end else if (q_pop_o) begin
      cur_valid_q <= 1'b1;
      phase_q     <= PhTag;
    end else if (finish) begin
      cur_valid_q <= 1'b0;
      phase_q     <= PhTag;
    end else if (fire) begin
      phase_q     <= phase_q + 2'd1;
    end
  end

  // Hold the entry payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end
  end

  `SFR_ASSERT(a_phase_only_hdr, (phase_q != PhTag) |-> (cur_valid_q && cur_q.hdr), "phase without header")

endmodule

// ===== rtl/serial_frame_receiver_crc8_top.sv =====
// ----------------------------------------------------------------------------
// Serial frame receiver with CRC-8 check
// Deframes length-framed serial packets and reports each frame's status.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries received bytes, one word per valid/ready handshake.
//   tx_o carries the bytes of kept frames in order, with first and last
//   marks; frame_status is valid with frame_last (good, CRC error, short).
//   Headers arrive in aligned groups of three; a group starting with 0xFF
//   and a length above 3 opens a frame, any other group is dropped.
//   A payload byte passes the entry queue and then the sequencer's held
//   entry to tx_o; a kept header follows as three words after its length
//   byte, and header words take no output slot until the group is done.
//   Throughput: one word per cycle in each direction while tx_o is ready;
//   the front end takes a byte every cycle while the entry queue has room,
//   and the sequencer drains one output word per cycle while tx_o is ready.
//   Reset clears the hunt state, the queue and the output stage; no frame
//   is in progress afterward.
//   When tx_o stalls, entries collect in the queue (QueueDepth entries),
//   then rx_i.ready drops until the output side resumes.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc8_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sfr_rx_if.sink   rx_i,
  sfr_tx_if.source tx_o
);

  logic                push;
  sfr_pkg::sfr_entry_t push_entry;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  sfr_pkg::sfr_entry_t q_head;

  // Classify received words
  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Decouple front and back
  sfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  // Sequence output words
  sfr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .tx_o      (tx_o)
  );

endmodule
